### sv/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge out of reset.
`define FLA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent checked in the same cycle as the trigger.
`define FLA_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// Consequent checked in the cycle after the trigger.
`define FLA_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

### sv/fla_pkg.sv
// Shared types and constants of the free list heap allocator.
// Used by the adder unit and the top level; depends on nothing.
package fla_pkg;

	localparam logic [31:0] GRAIN = 32'd8;
	localparam logic [31:0] HDR   = 32'd4;

	localparam int PADDR_W = 4;

	localparam logic [31:0] HEAP_BASE_RST    = 32'd0;
	localparam logic [31:0] HEAP_TOP_RST     = 32'd4096;
	localparam logic [15:0] STACK_MARGIN_RST = 16'd1024;

	localparam logic [1:0] REG_HEAP_BASE    = 2'd0;
	localparam logic [1:0] REG_HEAP_TOP     = 2'd1;
	localparam logic [1:0] REG_STACK_MARGIN = 2'd2;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OOM  = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] size;
	} chunk_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} alu_req_t;

	typedef struct packed {
		logic [33:0] sum;
	} alu_rsp_t;

endpackage

### sv/fla_alu.sv
// Shared three-operand adder of the allocator sequencer.
// Subtraction is a + ~b + 1, with bit 32 of the sum as the no-borrow flag.
module fla_alu (
	input  fla_pkg::alu_req_t req,
	output fla_pkg::alu_rsp_t rsp
);

	assign rsp.sum = {2'b00, req.a} + {2'b00, req.b} + {2'b00, req.c};

endmodule

### sv/free_list_heap_allocator_core.sv
// Best-fit heap allocator with an address-sorted free table and per-block size headers.
// One request at a time: in_ready is high only while the sequencer is idle, and a finished
// word waits in the output register while the next request is taken. An allocate scans the
// free table for an exact fit, which ends the scan, or else keeps the best fit; it then takes
// the best fit whole, splits it, or cuts a new block from the break, and taking a chunk out
// of the table shifts the entries above it down. A release on top of the heap pulls the
// break back and, when the table is not empty, also takes in a last free chunk that ends at
// the new break; otherwise it searches for its slot, then inserts a new entry by shifting the
// entries above it up, or merges with its neighbours, shifting down on a merge on both sides.
// One table read per cycle goes through the shared adder and the table's single read port.
// A finished request may also wait for the output register. No clearing pass follows reset.
`include "assert_macros.svh"

module free_list_heap_allocator_core #(
	parameter int HEAP_BYTES      = 4096,
	parameter int MAX_FREE_CHUNKS = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fla_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        op,
	input  logic [31:0]                 request_length,
	input  logic [31:0]                 release_address,
	input  logic [31:0]                 stack_position,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [31:0]                 payload_address,
	output logic [1:0]                  status
);

	localparam int HDR_WORDS = HEAP_BYTES / 4;
	localparam int HW        = $clog2(HDR_WORDS);
	localparam int CW        = $clog2(MAX_FREE_CHUNKS);
	localparam int CNTW      = $clog2(MAX_FREE_CHUNKS + 1);
	localparam logic [31:0]     HDR_LIM = 32'(HDR_WORDS * 4);
	localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_FREE_CHUNKS);

	typedef enum logic [27:0] {
		S_IDLE   = 28'h0000001,
		S_ROUND  = 28'h0000002,
		S_SCAN   = 28'h0000004,
		S_PICK   = 28'h0000008,
		S_TAKE   = 28'h0000010,
		S_SPLIT  = 28'h0000020,
		S_SPLIT2 = 28'h0000040,
		S_SPLIT3 = 28'h0000080,
		S_BRK0   = 28'h0000100,
		S_BRK1   = 28'h0000200,
		S_BRK2   = 28'h0000400,
		S_BRK3   = 28'h0000800,
		S_BRK4   = 28'h0001000,
		S_HDR_WR = 28'h0002000,
		S_SHDN   = 28'h0004000,
		S_REL0   = 28'h0008000,
		S_REL1   = 28'h0010000,
		S_REL2   = 28'h0020000,
		S_REL3   = 28'h0040000,
		S_TOP0   = 28'h0080000,
		S_TOP1   = 28'h0100000,
		S_FIND   = 28'h0200000,
		S_LINK   = 28'h0400000,
		S_LINK2  = 28'h0800000,
		S_MRG    = 28'h1000000,
		S_MRG2   = 28'h2000000,
		S_SHUP   = 28'h4000000,
		S_DONE   = 28'h8000000
	} state_t;

	state_t state_q;

	// configuration
	logic [31:0] heap_base_q, heap_top_q;
	logic [15:0] stack_margin_q;
	logic        cfg_wr;

	// request and working registers
	logic [31:0] len_q, p_q, sp_q, h_q, sz_q;
	logic [31:0] pay_q, hdr_addr_q, hdr_data_q, diff_q, stk_q, avail_q, m_q;
	logic [1:0]  stat_q;
	logic        rm_q, found_q, hdr_ok_q, nxt_vld_q, mnext_q, mprev_q;
	logic [CNTW-1:0] count_q, rd_q, wr_q, sel_idx_q, best_idx_q, ev_idx_s1;
	logic            ev_vld_s1;
	fla_pkg::chunk_t best_q, ent_q, prv_q;
	logic [31:0] brk_q;
	logic        brk_valid_q;
	logic [31:0] out_pay_q;
	logic [1:0]  out_stat_q;
	logic        out_valid_q;

	// memories
	fla_pkg::chunk_t chunk_mem [MAX_FREE_CHUNKS];
	fla_pkg::chunk_t chunk_rd_q;
	logic [31:0]     hdr_mem [HDR_WORDS];
	logic [31:0]     hdr_rd_q;

	logic [CW-1:0]   chunk_raddr, chunk_waddr;
	logic            chunk_we;
	fla_pkg::chunk_t chunk_wdata;
	logic            hdr_we;
	logic [HW-1:0]   hdr_idx;
	logic            hdr_in_range;

	fla_pkg::alu_req_t alu_req;
	fla_pkg::alu_rsp_t alu_rsp;
	logic [31:0]       alu_lo;
	logic              rd_more;
	logic [31:0]       lim;
	logic [CNTW-1:0]   sel_m1, cnt_m1, rd_m1;

	fla_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	assign alu_lo       = alu_rsp.sum[31:0];
	assign hdr_in_range = alu_lo < HDR_LIM;
	assign hdr_idx      = alu_lo[HW+1:2];
	assign lim          = (stk_q < heap_top_q) ? stk_q : heap_top_q;
	assign sel_m1       = sel_idx_q - CNTW'(1);
	assign cnt_m1       = count_q - CNTW'(1);
	assign rd_m1        = rd_q - CNTW'(1);

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign payload_address = out_pay_q;
	assign status    = out_stat_q;

	always_comb begin
		unique case (paddr[3:2])
			fla_pkg::REG_HEAP_BASE:    prdata = heap_base_q;
			fla_pkg::REG_HEAP_TOP:     prdata = heap_top_q;
			fla_pkg::REG_STACK_MARGIN: prdata = {16'd0, stack_margin_q};
			default:                   prdata = 32'd0;
		endcase
	end

	always_comb begin
		rd_more = (state_q == S_SHUP) ? (rd_q > sel_idx_q) : (rd_q < count_q);
	end

	// operand select for the shared adder and memory port control
	always_comb begin
		alu_req     = '0;
		chunk_raddr = rd_q[CW-1:0];
		chunk_we    = 1'b0;
		chunk_waddr = wr_q[CW-1:0];
		chunk_wdata = chunk_rd_q;
		hdr_we      = 1'b0;
		unique case (state_q)
			S_ROUND: begin
				alu_req.a = len_q;
				alu_req.b = fla_pkg::GRAIN - 32'd1;
			end
			S_PICK: begin
				alu_req.a = best_q.size;
				alu_req.b = ~len_q;
				alu_req.c = 32'd1;
			end
			S_TAKE, S_SPLIT2: begin
				alu_req.a = hdr_addr_q;
				alu_req.b = fla_pkg::HDR;
			end
			S_SPLIT: begin
				alu_req.a = best_q.start;
				alu_req.b = diff_q;
			end
			S_SPLIT3: begin
				alu_req.a   = diff_q;
				alu_req.b   = ~fla_pkg::HDR;
				alu_req.c   = 32'd1;
				chunk_we    = 1'b1;
				chunk_waddr = best_idx_q[CW-1:0];
				chunk_wdata = '{start: best_q.start, size: alu_lo};
			end
			S_BRK0: begin
				alu_req.a = sp_q;
				alu_req.b = ~{16'd0, stack_margin_q};
				alu_req.c = 32'd1;
			end
			S_BRK1: begin
				alu_req.a = lim;
				alu_req.b = ~brk_q;
				alu_req.c = 32'd1;
			end
			S_BRK2: begin
				alu_req.a = len_q;
				alu_req.b = fla_pkg::HDR;
			end
			S_BRK3: begin
				alu_req.a = brk_q;
				alu_req.b = fla_pkg::HDR;
			end
			S_BRK4: begin
				alu_req.a = brk_q;
				alu_req.b = len_q;
				alu_req.c = fla_pkg::HDR;
			end
			S_HDR_WR: begin
				alu_req.a = hdr_addr_q;
				alu_req.b = ~heap_base_q;
				alu_req.c = 32'd1;
				hdr_we    = hdr_in_range;
			end
			S_SHDN: begin
				chunk_we = ev_vld_s1;
			end
			S_REL0: begin
				alu_req.a = p_q;
				alu_req.b = ~fla_pkg::HDR;
				alu_req.c = 32'd1;
			end
			S_REL1: begin
				alu_req.a = h_q;
				alu_req.b = ~heap_base_q;
				alu_req.c = 32'd1;
			end
			S_REL3: begin
				alu_req.a = p_q;
				alu_req.b = sz_q;
			end
			S_TOP0: begin
				chunk_raddr = cnt_m1[CW-1:0];
			end
			S_TOP1: begin
				alu_req.a = chunk_rd_q.start;
				alu_req.b = chunk_rd_q.size;
				alu_req.c = fla_pkg::HDR;
			end
			S_LINK: begin
				alu_req.a = h_q;
				alu_req.b = sz_q;
				alu_req.c = fla_pkg::HDR;
			end
			S_LINK2: begin
				alu_req.a = prv_q.start;
				alu_req.b = prv_q.size;
				alu_req.c = fla_pkg::HDR;
			end
			S_MRG: begin
				alu_req.a = sz_q;
				alu_req.b = mnext_q ? ent_q.size : 32'd0;
				alu_req.c = mnext_q ? fla_pkg::HDR : 32'd0;
			end
			S_MRG2: begin
				alu_req.a = prv_q.size;
				alu_req.b = m_q;
				alu_req.c = fla_pkg::HDR;
				if (mprev_q) begin
					chunk_we    = 1'b1;
					chunk_waddr = sel_m1[CW-1:0];
					chunk_wdata = '{start: prv_q.start, size: alu_lo};
				end else if (mnext_q) begin
					chunk_we    = 1'b1;
					chunk_waddr = sel_idx_q[CW-1:0];
					chunk_wdata = '{start: h_q, size: m_q};
				end
			end
			S_SHUP: begin
				chunk_raddr = rd_m1[CW-1:0];
				if (ev_vld_s1) begin
					chunk_we = 1'b1;
				end else if (!rd_more) begin
					// drop the new entry into the opened slot
					chunk_we    = 1'b1;
					chunk_waddr = sel_idx_q[CW-1:0];
					chunk_wdata = '{start: h_q, size: sz_q};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (chunk_we) begin
			chunk_mem[chunk_waddr] <= chunk_wdata;
		end
		chunk_rd_q <= chunk_mem[chunk_raddr];
	end

	always_ff @(posedge clk) begin
		if (hdr_we) begin
			hdr_mem[hdr_idx] <= hdr_data_q;
		end
		hdr_rd_q <= hdr_mem[hdr_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q    <= fla_pkg::HEAP_BASE_RST;
			heap_top_q     <= fla_pkg::HEAP_TOP_RST;
			stack_margin_q <= fla_pkg::STACK_MARGIN_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				fla_pkg::REG_HEAP_BASE:    heap_base_q    <= pwdata;
				fla_pkg::REG_HEAP_TOP:     heap_top_q     <= pwdata;
				fla_pkg::REG_STACK_MARGIN: stack_margin_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			brk_q       <= '0;
			brk_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_pay_q   <= '0;
			out_stat_q  <= fla_pkg::ST_OK;
			ev_vld_s1   <= 1'b0;
			ev_idx_s1   <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			sel_idx_q   <= '0;
			best_idx_q  <= '0;
			len_q       <= '0;
			p_q         <= '0;
			sp_q        <= '0;
			h_q         <= '0;
			sz_q        <= '0;
			pay_q       <= '0;
			stat_q      <= fla_pkg::ST_OK;
			hdr_addr_q  <= '0;
			hdr_data_q  <= '0;
			diff_q      <= '0;
			stk_q       <= '0;
			avail_q     <= '0;
			m_q         <= '0;
			rm_q        <= 1'b0;
			found_q     <= 1'b0;
			hdr_ok_q    <= 1'b0;
			nxt_vld_q   <= 1'b0;
			mnext_q     <= 1'b0;
			mprev_q     <= 1'b0;
			best_q      <= '0;
			ent_q       <= '0;
			prv_q       <= '0;
		end else begin
			// S_DONE reloads the output register itself
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						len_q  <= request_length;
						p_q    <= release_address;
						sp_q   <= stack_position;
						pay_q  <= '0;
						stat_q <= fla_pkg::ST_OK;
						state_q <= (op == fla_pkg::OP_RELEASE) ? S_REL0 : S_ROUND;
					end
				end
				S_ROUND: begin
					if (len_q == 32'd0) begin
						stat_q  <= fla_pkg::ST_BAD;
						state_q <= S_DONE;
					end else if (alu_rsp.sum[32]) begin
						stat_q  <= fla_pkg::ST_OOM;
						state_q <= S_DONE;
					end else begin
						len_q     <= alu_lo & ~(fla_pkg::GRAIN - 32'd1);
						rd_q      <= '0;
						ev_vld_s1 <= 1'b0;
						found_q   <= 1'b0;
						state_q   <= S_SCAN;
					end
				end
				S_SCAN: begin
					ev_vld_s1 <= rd_more;
					ev_idx_s1 <= rd_q;
					if (rd_more) begin
						rd_q <= rd_q + CNTW'(1);
					end
					if (ev_vld_s1) begin
						if (chunk_rd_q.size == len_q) begin
							sel_idx_q  <= ev_idx_s1;
							hdr_addr_q <= chunk_rd_q.start;
							hdr_data_q <= chunk_rd_q.size;
							rm_q       <= 1'b1;
							state_q    <= S_TAKE;
						end else if (chunk_rd_q.size > len_q &&
							(!found_q || chunk_rd_q.size < best_q.size)) begin
							best_q     <= chunk_rd_q;
							best_idx_q <= ev_idx_s1;
							found_q    <= 1'b1;
						end
					end else if (!rd_more) begin
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					if (!found_q) begin
						state_q <= S_BRK0;
					end else if (alu_lo < fla_pkg::GRAIN) begin
						// remainder too small to keep: take the chunk whole
						sel_idx_q  <= best_idx_q;
						hdr_addr_q <= best_q.start;
						hdr_data_q <= best_q.size;
						rm_q       <= 1'b1;
						state_q    <= S_TAKE;
					end else begin
						diff_q  <= alu_lo;
						state_q <= S_SPLIT;
					end
				end
				S_TAKE: begin
					pay_q   <= alu_lo;
					state_q <= S_HDR_WR;
				end
				S_SPLIT: begin
					hdr_addr_q <= alu_lo;
					hdr_data_q <= len_q;
					state_q    <= S_SPLIT2;
				end
				S_SPLIT2: begin
					pay_q   <= alu_lo;
					state_q <= S_SPLIT3;
				end
				S_SPLIT3: begin
					rm_q    <= 1'b0;
					state_q <= S_HDR_WR;
				end
				S_BRK0: begin
					if (!brk_valid_q) begin
						brk_q       <= heap_base_q;
						brk_valid_q <= 1'b1;
					end
					stk_q   <= alu_rsp.sum[32] ? alu_lo : 32'd0;
					state_q <= S_BRK1;
				end
				S_BRK1: begin
					avail_q <= alu_rsp.sum[32] ? alu_lo : 32'd0;
					state_q <= S_BRK2;
				end
				S_BRK2: begin
					if ({1'b0, avail_q} >= alu_rsp.sum[32:0]) begin
						hdr_addr_q <= brk_q;
						hdr_data_q <= len_q;
						rm_q       <= 1'b0;
						state_q    <= S_BRK3;
					end else begin
						stat_q  <= fla_pkg::ST_OOM;
						state_q <= S_DONE;
					end
				end
				S_BRK3: begin
					pay_q   <= alu_lo;
					state_q <= S_BRK4;
				end
				S_BRK4: begin
					brk_q   <= alu_lo;
					state_q <= S_HDR_WR;
				end
				S_HDR_WR: begin
					if (rm_q) begin
						rd_q      <= sel_idx_q + CNTW'(1);
						wr_q      <= sel_idx_q;
						ev_vld_s1 <= 1'b0;
						state_q   <= S_SHDN;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SHDN: begin
					ev_vld_s1 <= rd_more;
					if (rd_more) begin
						rd_q <= rd_q + CNTW'(1);
					end
					if (ev_vld_s1) begin
						wr_q <= wr_q + CNTW'(1);
					end
					if (!rd_more && !ev_vld_s1) begin
						count_q <= cnt_m1;
						state_q <= S_DONE;
					end
				end
				S_REL0: begin
					if (p_q == 32'd0) begin
						stat_q  <= fla_pkg::ST_BAD;
						state_q <= S_DONE;
					end else begin
						h_q     <= alu_lo;
						state_q <= S_REL1;
					end
				end
				S_REL1: begin
					hdr_ok_q <= hdr_in_range;
					state_q  <= S_REL2;
				end
				S_REL2: begin
					sz_q    <= hdr_ok_q ? hdr_rd_q : 32'd0;
					state_q <= S_REL3;
				end
				S_REL3: begin
					if (brk_valid_q && alu_lo == brk_q) begin
						// block sits on top: pull the break back
						brk_q   <= h_q;
						state_q <= (count_q != '0) ? S_TOP0 : S_DONE;
					end else begin
						rd_q      <= '0;
						ev_vld_s1 <= 1'b0;
						state_q   <= S_FIND;
					end
				end
				S_TOP0: begin
					state_q <= S_TOP1;
				end
				S_TOP1: begin
					if (alu_lo == h_q) begin
						brk_q   <= chunk_rd_q.start;
						count_q <= cnt_m1;
					end
					state_q <= S_DONE;
				end
				S_FIND: begin
					ev_vld_s1 <= rd_more;
					ev_idx_s1 <= rd_q;
					if (rd_more) begin
						rd_q <= rd_q + CNTW'(1);
					end
					if (ev_vld_s1) begin
						if (chunk_rd_q.start < h_q) begin
							prv_q <= chunk_rd_q;
						end else begin
							sel_idx_q <= ev_idx_s1;
							ent_q     <= chunk_rd_q;
							nxt_vld_q <= 1'b1;
							state_q   <= S_LINK;
						end
					end else if (!rd_more) begin
						sel_idx_q <= count_q;
						nxt_vld_q <= 1'b0;
						state_q   <= S_LINK;
					end
				end
				S_LINK: begin
					mnext_q <= nxt_vld_q && (alu_lo == ent_q.start);
					state_q <= S_LINK2;
				end
				S_LINK2: begin
					mprev_q <= (sel_idx_q != '0) && (alu_lo == h_q);
					state_q <= S_MRG;
				end
				S_MRG: begin
					m_q     <= alu_lo;
					state_q <= S_MRG2;
				end
				S_MRG2: begin
					if (mprev_q) begin
						if (mnext_q) begin
							rd_q      <= sel_idx_q + CNTW'(1);
							wr_q      <= sel_idx_q;
							ev_vld_s1 <= 1'b0;
							state_q   <= S_SHDN;
						end else begin
							state_q <= S_DONE;
						end
					end else if (mnext_q) begin
						state_q <= S_DONE;
					end else if (count_q >= MAX_CNT) begin
						stat_q  <= fla_pkg::ST_FULL;
						state_q <= S_DONE;
					end else begin
						rd_q      <= count_q;
						wr_q      <= count_q;
						ev_vld_s1 <= 1'b0;
						state_q   <= S_SHUP;
					end
				end
				S_SHUP: begin
					ev_vld_s1 <= rd_more;
					if (rd_more) begin
						rd_q <= rd_m1;
					end
					if (ev_vld_s1) begin
						wr_q <= wr_q - CNTW'(1);
					end
					if (!rd_more && !ev_vld_s1) begin
						count_q <= count_q + CNTW'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hold until the output register frees up
					if (!out_valid_q || out_ready) begin
						out_pay_q   <= pay_q;
						out_stat_q  <= stat_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`FLA_ASSERT(a_cnt_max, count_q <= MAX_CNT, "free table count above its depth")
	`FLA_ASSERT(a_cnt_step, (count_q - $past(count_q) + CNTW'(1)) <= CNTW'(2), "count jumped")
	`FLA_ASSERT_NEXT(a_brk_idle, state_q == S_IDLE, $stable(brk_q), "break moved while idle")
	`FLA_ASSERT_NOW(a_shup_room, state_q == S_SHUP, count_q < MAX_CNT, "insert into full table")
	`FLA_ASSERT_NEXT(a_done_out, (state_q == S_DONE) && out_ready, out_valid_q, "word not shown")

endmodule

### verif/free_list_heap_allocator_core_tb.sv
// Self-checking testbench for free_list_heap_allocator_core.
// Drives allocate/release words and APB register writes; an in-file scoreboard
// predicts every result. Depends on fla_pkg and the core RTL only.
`timescale 1ns / 1ps

module free_list_heap_allocator_core_tb;

	localparam int HEAP_BYTES      = 4096;
	localparam int MAX_FREE_CHUNKS = 128;
	localparam int HDR_WORDS       = HEAP_BYTES / 4;
	localparam logic [31:0] SP_HIGH = 32'hFFFF_FFF0;

	class alloc_scoreboard;
		bit [31:0] base = fla_pkg::HEAP_BASE_RST;
		bit [31:0] top = fla_pkg::HEAP_TOP_RST;
		bit [15:0] margin = fla_pkg::STACK_MARGIN_RST;
		bit [31:0] free_start[MAX_FREE_CHUNKS];
		bit [31:0] free_size[MAX_FREE_CHUNKS];
		int free_count = 0;
		bit [31:0] brk = 0;
		bit brk_ok = 0;
		bit [31:0] hdr_size[HDR_WORDS];
		bit hdr_seen[HDR_WORDS];
		bit [31:0] exp_addr[$];
		bit [1:0] exp_status[$];
		bit [31:0] live[$];
		int errors = 0;
		int n_alloc_ok = 0, n_oom = 0, n_bad = 0, n_full = 0, n_release = 0, n_checked = 0;

		function void set_reg(logic [1:0] idx, bit [31:0] v);
			if (idx == fla_pkg::REG_HEAP_BASE) base = v;
			else if (idx == fla_pkg::REG_HEAP_TOP) top = v;
			else if (idx == fla_pkg::REG_STACK_MARGIN) margin = v[15:0];
		endfunction

		function void hdr_write(bit [31:0] a, bit [31:0] sz);
			bit [31:0] off;
			off = a - base;
			if (off < HEAP_BYTES) begin
				hdr_size[off >> 2] = sz;
				hdr_seen[off >> 2] = 1;
			end
		endfunction

		function bit [31:0] hdr_read(bit [31:0] a);
			bit [31:0] off;
			off = a - base;
			if (off < HEAP_BYTES) return hdr_size[off >> 2];
			return 0;
		endfunction

		// a release may only touch headers that were written at some point
		function bit safe_release(bit [31:0] p);
			bit [31:0] off;
			off = p - fla_pkg::HDR - base;
			if (p == 0 || off >= HEAP_BYTES) return 1;
			return hdr_seen[off >> 2];
		endfunction

		function void drop_chunk(int i);
			for (int k = i; k + 1 < free_count; k++) begin
				free_start[k] = free_start[k + 1];
				free_size[k] = free_size[k + 1];
			end
			free_count--;
		endfunction

		function bit [31:0] allocate(bit [31:0] req, bit [31:0] sp, output bit [1:0] st);
			longint unsigned ln, s, stk, lim, avail;
			int best;
			bit found;
			bit [31:0] at;
			best = 0;
			found = 0;
			ln = req;
			if (ln == 0) begin
				st = fla_pkg::ST_BAD;
				return 0;
			end
			if (ln < fla_pkg::GRAIN) ln = fla_pkg::GRAIN;
			ln = (ln + 7) & ~64'd7;
			if (ln > 64'hFFFF_FFFF) begin
				st = fla_pkg::ST_OOM;
				return 0;
			end
			for (int i = 0; i < free_count; i++) begin
				if (free_size[i] == ln) begin
					at = free_start[i];
					hdr_write(at, free_size[i]);
					drop_chunk(i);
					st = fla_pkg::ST_OK;
					return at + fla_pkg::HDR;
				end
				if (free_size[i] > ln && (!found || free_size[i] < free_size[best])) begin
					best = i;
					found = 1;
				end
			end
			if (found) begin
				s = free_size[best];
				st = fla_pkg::ST_OK;
				if (s - ln < fla_pkg::GRAIN) begin
					at = free_start[best];
					hdr_write(at, s[31:0]);
					drop_chunk(best);
				end else begin
					// carve from the top of the chunk, keep the bottom free
					at = free_start[best] + 32'(s - ln);
					hdr_write(at, ln[31:0]);
					free_size[best] = 32'(s - ln - fla_pkg::HDR);
				end
				return at + fla_pkg::HDR;
			end
			if (!brk_ok) begin
				brk = base;
				brk_ok = 1;
			end
			stk = (sp >= margin) ? longint'(sp - margin) : 0;
			lim = (stk < top) ? stk : top;
			avail = (lim >= brk) ? lim - brk : 0;
			if (avail >= ln + fla_pkg::HDR) begin
				at = brk;
				hdr_write(at, ln[31:0]);
				brk = brk + ln[31:0] + fla_pkg::HDR;
				st = fla_pkg::ST_OK;
				return at + fla_pkg::HDR;
			end
			st = fla_pkg::ST_OOM;
			return 0;
		endfunction

		function bit [1:0] release_block(bit [31:0] p);
			bit [31:0] h, sz, merged;
			bit mnext, mprev;
			int i;
			if (p == 0) return fla_pkg::ST_BAD;
			h = p - fla_pkg::HDR;
			sz = hdr_read(h);
			if (brk_ok && p + sz == brk) begin
				brk = h;
				if (free_count > 0) begin
					i = free_count - 1;
					if (free_start[i] + fla_pkg::HDR + free_size[i] == brk) begin
						brk = free_start[i];
						free_count--;
					end
				end
				return fla_pkg::ST_OK;
			end
			i = 0;
			while (i < free_count && free_start[i] < h) i++;
			mnext = i < free_count && h + fla_pkg::HDR + sz == free_start[i];
			mprev = i > 0 && free_start[i - 1] + fla_pkg::HDR + free_size[i - 1] == h;
			merged = mnext ? sz + free_size[i] + fla_pkg::HDR : sz;
			if (mnext && mprev) begin
				free_size[i - 1] += merged + fla_pkg::HDR;
				drop_chunk(i);
			end else if (mnext) begin
				free_start[i] = h;
				free_size[i] = merged;
			end else if (mprev) begin
				free_size[i - 1] += sz + fla_pkg::HDR;
			end else begin
				if (free_count >= MAX_FREE_CHUNKS) return fla_pkg::ST_FULL;
				for (int k = free_count; k > i; k--) begin
					free_start[k] = free_start[k - 1];
					free_size[k] = free_size[k - 1];
				end
				free_start[i] = h;
				free_size[i] = sz;
				free_count++;
			end
			return fla_pkg::ST_OK;
		endfunction

		function void note_input(logic o, bit [31:0] req, bit [31:0] rel, bit [31:0] sp);
			bit [31:0] a;
			bit [1:0] st;
			a = 0;
			if (o == fla_pkg::OP_ALLOC) begin
				a = allocate(req, sp, st);
				if (st == fla_pkg::ST_OK) begin
					live.push_back(a);
					n_alloc_ok++;
				end
			end else begin
				st = release_block(rel);
				n_release++;
			end
			if (st == fla_pkg::ST_OOM) n_oom++;
			if (st == fla_pkg::ST_BAD) n_bad++;
			if (st == fla_pkg::ST_FULL) n_full++;
			exp_addr.push_back(a);
			exp_status.push_back(st);
		endfunction

		function void check_result(bit [31:0] a, bit [1:0] st);
			bit [31:0] ea;
			bit [1:0] es;
			if (exp_addr.size() == 0) begin
				$error("result word with nothing expected: addr %h status %0d", a, st);
				errors++;
				return;
			end
			ea = exp_addr.pop_front();
			es = exp_status.pop_front();
			n_checked++;
			if (a !== ea) begin
				$error("payload_address: expected %h, got %h", ea, a);
				errors++;
			end
			if (st !== es) begin
				$error("status: expected %0d, got %0d", es, st);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [fla_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_ready;
	logic op = fla_pkg::OP_ALLOC;
	logic [31:0] request_length = '0, release_address = '0, stack_position = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [31:0] payload_address;
	logic [1:0] status;

	int send_idle = 0;
	int recv_idle = 0;
	alloc_scoreboard sb = new();

	free_list_heap_allocator_core #(
		.HEAP_BYTES(HEAP_BYTES),
		.MAX_FREE_CHUNKS(MAX_FREE_CHUNKS)
	) dut (.*);

	always #4 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_result(payload_address, status);
			if (in_valid && in_ready) sb.note_input(op, request_length, release_address,
				stack_position);
		end
	end

	initial begin
		#50ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// call at a falling edge; returns at the falling edge after acceptance
	task automatic send_word(logic o, logic [31:0] req, logic [31:0] rel, logic [31:0] sp);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1;
		op <= o;
		request_length <= req;
		release_address <= rel;
		stack_position <= sp;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic do_alloc(logic [31:0] req, logic [31:0] sp);
		send_word(fla_pkg::OP_ALLOC, req, $urandom, sp);
	endtask

	task automatic do_release(logic [31:0] p);
		if (!sb.safe_release(p)) p = 0;
		send_word(fla_pkg::OP_RELEASE, $urandom, p, $urandom);
	endtask

	// release a live block picked at random (or the one at index idx when 0 <= idx < live.size())
	task automatic release_live(int idx);
		bit [31:0] p;
		if (sb.live.size() == 0) begin
			do_release(0);
			return;
		end
		if (idx < 0 || idx >= sb.live.size()) idx = $urandom_range(sb.live.size() - 1);
		p = sb.live[idx];
		sb.live.delete(idx);
		do_release(p);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.exp_addr.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] v);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= fla_pkg::PADDR_W'(idx) << 2;
		pwdata <= v;
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, v);
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic random_word();
		int pick;
		bit [31:0] sp, p;
		pick = $urandom_range(99);
		sp = ($urandom_range(9) == 0) ? $urandom : SP_HIGH - $urandom_range(255);
		if (pick < 45) begin
			case ($urandom_range(19))
				0: do_alloc(0, sp);
				1: do_alloc($urandom, sp);
				2: do_alloc(32'hFFFF_FFFF - $urandom_range(15), sp);
				3, 4: do_alloc($urandom_range(65, 600), sp);
				default: do_alloc($urandom_range(1, 64), sp);
			endcase
		end else if (pick < 85) begin
			release_live(-1);
		end else if (pick < 91) begin
			// release of a block that may already be free
			p = sb.base + fla_pkg::HDR + ($urandom_range(HDR_WORDS - 1) << 2);
			do_release(p);
		end else if (pick < 96) begin
			p = $urandom;
			do_release(p);
		end else begin
			// fragment: small blocks, then free every other one
			for (int k = 0; k < 24; k++) do_alloc($urandom_range(1, 8), SP_HIGH);
			for (int k = sb.live.size() - 24; k >= 0 && k < sb.live.size(); k += 1)
				release_live(k);
		end
	endtask

	initial begin
		int phase_items;
		repeat (3) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		write_reg(fla_pkg::REG_HEAP_BASE, 0);
		write_reg(fla_pkg::REG_HEAP_TOP, 4096);
		write_reg(fla_pkg::REG_STACK_MARGIN, 1024);

		// directed corners
		send_idle = 26;
		recv_idle = 50;
		do_alloc(0, SP_HIGH);
		do_alloc(1, SP_HIGH);
		do_alloc(8, SP_HIGH);
		do_alloc(9, SP_HIGH);
		do_alloc(40, SP_HIGH);
		do_alloc(20, SP_HIGH);
		do_alloc(12, SP_HIGH);
		do_alloc(32'hFFFF_FFFF, SP_HIGH);
		do_alloc(32'hFFFF_FFF8, SP_HIGH);
		do_alloc(8, 100);
		do_alloc(8, 0);
		do_alloc(8, 32'hFFFF_FFFF);
		do_release(0);
		do_release(sb.base + 32'd8192 + fla_pkg::HDR);
		release_live(1);
		release_live(2);
		release_live(3);
		do_alloc(8, SP_HIGH);
		do_alloc(16, SP_HIGH);
		do_alloc(12, SP_HIGH);
		release_live(sb.live.size() - 1);
		do_release(sb.base + fla_pkg::HDR);
		do_release(sb.base + fla_pkg::HDR);
		do_alloc(3000, SP_HIGH);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 26 : (ph == 1) ? 50 : 0;
			recv_idle = (ph == 0) ? 50 : (ph == 1) ? 26 : 0;
			case (ph)
				1: begin
					write_reg(fla_pkg::REG_STACK_MARGIN, 16'hFFFF);
					write_reg(fla_pkg::REG_HEAP_TOP, 32'hFFFF_FFFF);
				end
				2: begin
					write_reg(fla_pkg::REG_STACK_MARGIN, 0);
					write_reg(fla_pkg::REG_HEAP_TOP, 32'd2048);
				end
				default: ;
			endcase
			phase_items = sb.n_checked + 240;
			while (sb.n_checked + sb.exp_addr.size() < phase_items) random_word();
			drain();
		end

		// base register at its maximum, then at a nonzero offset
		write_reg(fla_pkg::REG_HEAP_BASE, 32'hFFFF_FFFF);
		write_reg(fla_pkg::REG_HEAP_TOP, 0);
		for (int k = 0; k < 10; k++) random_word();
		drain();
		write_reg(fla_pkg::REG_HEAP_BASE, 32'h0000_0100);
		write_reg(fla_pkg::REG_HEAP_TOP, 32'h0000_1100);
		for (int k = 0; k < 10; k++) random_word();
		drain();

		$display("Checked %0d result words: %0d allocations, %0d releases,", sb.n_checked,
			sb.n_alloc_ok, sb.n_release);
		$display("  %0d out of memory, %0d zero/null, %0d dropped on full table.", sb.n_oom,
			sb.n_bad, sb.n_full);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
